// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros shared by the console rtl
// both macros check on the rising clock edge and are off while reset is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// expression holds at every edge
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// consequent holds at every edge where the antecedent holds
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg)
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/tccw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccw_pkg
// shared constants and types of the text console character writer
// ----------------------------------------------------------------------------
package tccw_pkg;

    // default screen geometry
    localparam int DEF_COLS = 80;
    localparam int DEF_ROWS = 25;

    // beat field widths
    localparam int CHAR_W     = 8;
    localparam int COLOR_W    = 4;
    localparam int CELL_W     = 16;
    localparam int PORT_ROW_W = 5;
    localparam int PORT_COL_W = 7;

    // opcodes
    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_READ = 1'b1;

    // control characters
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;

    // control flags of one put step
    typedef struct packed {
        logic wr_en;
        logic scroll;
    } t_put_ctl;

endpackage

// ===== rtl/tccw_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccw_in_if
// command channel: put character or read cell
// ----------------------------------------------------------------------------
interface tccw_in_if;
    logic                              valid;
    logic                              ready;
    logic                              opcode;
    logic [tccw_pkg::CHAR_W-1:0]       char_code;
    logic [tccw_pkg::COLOR_W-1:0]      back_color;
    logic [tccw_pkg::COLOR_W-1:0]      fore_color;
    logic [tccw_pkg::PORT_ROW_W-1:0]   read_row;
    logic [tccw_pkg::PORT_COL_W-1:0]   read_col;

    modport source (
        output valid, opcode, char_code, back_color, fore_color, read_row, read_col,
        input  ready
    );
    modport sink (
        input  valid, opcode, char_code, back_color, fore_color, read_row, read_col,
        output ready
    );
endinterface

// ===== rtl/tccw_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccw_out_if
// result channel: read cell value and cursor after the step
// ----------------------------------------------------------------------------
interface tccw_out_if;
    logic                              valid;
    logic                              ready;
    logic [tccw_pkg::CELL_W-1:0]       cell_value;
    logic [tccw_pkg::PORT_COL_W-1:0]   cursor_col;
    logic [tccw_pkg::PORT_ROW_W-1:0]   cursor_row;
    logic                              did_scroll;

    modport source (
        output valid, cell_value, cursor_col, cursor_row, did_scroll,
        input  ready
    );
    modport sink (
        input  valid, cell_value, cursor_col, cursor_row, did_scroll,
        output ready
    );
endinterface

// ===== rtl/tccw_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccw_ram
// single port synchronous ram with registered read data
// ----------------------------------------------------------------------------
module tccw_ram #(
    parameter int WIDTH = tccw_pkg::CELL_W,
    parameter int DEPTH = tccw_pkg::DEF_COLS * tccw_pkg::DEF_ROWS
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/tccw_cursor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccw_cursor
// plans one put step: cell to write and the cursor that follows
// ----------------------------------------------------------------------------
module tccw_cursor #(
    parameter int COLS = tccw_pkg::DEF_COLS,
    parameter int ROWS = tccw_pkg::DEF_ROWS,
    localparam int CW  = $clog2(COLS),
    localparam int RW  = $clog2(ROWS)
) (
    input  logic [CW-1:0]                   i_col,
    input  logic [RW-1:0]                   i_row,
    input  logic [RW-1:0]                   i_prow,
    input  logic [RW-1:0]                   i_top,
    input  logic [tccw_pkg::CHAR_W-1:0]     i_char,
    input  logic [tccw_pkg::COLOR_W-1:0]    i_back,
    input  logic [tccw_pkg::COLOR_W-1:0]    i_fore,
    output tccw_pkg::t_put_ctl              o_ctl,
    output logic [RW-1:0]                   o_wr_prow,
    output logic [CW-1:0]                   o_wr_col,
    output logic [tccw_pkg::CELL_W-1:0]     o_wr_data,
    output logic [CW-1:0]                   o_n_col,
    output logic [RW-1:0]                   o_n_row,
    output logic [RW-1:0]                   o_n_prow
);

    localparam logic [CW-1:0] LAST_COL = CW'(COLS - 1);
    localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);

    logic          at_bot;
    logic          at_home;
    logic [RW-1:0] prow_next;
    logic [RW-1:0] prow_prev;

    // physical row neighbors in the circular row buffer
    assign at_bot    = (i_row == LAST_ROW);
    assign at_home   = (i_row == '0) && (i_col == '0);
    assign prow_next = (i_prow == LAST_ROW) ? '0 : i_prow + 1'b1;
    assign prow_prev = (i_prow == '0) ? LAST_ROW : i_prow - 1'b1;

    // step plan per character class
    always_comb begin
        o_ctl     = '0;
        o_wr_prow = i_prow;
        o_wr_col  = i_col;
        o_wr_data = '0;
        o_n_col   = i_col;
        o_n_row   = i_row;
        o_n_prow  = i_prow;
        case (i_char)
            tccw_pkg::CH_NEWLINE: begin
                o_n_col = '0;
                if (at_bot) begin
                    // old top row becomes the new bottom row
                    o_ctl.scroll = 1'b1;
                    o_n_prow     = i_top;
                end else begin
                    o_n_row  = i_row + 1'b1;
                    o_n_prow = prow_next;
                end
            end
            tccw_pkg::CH_BACKSPACE: begin
                if (!at_home) begin
                    o_ctl.wr_en = 1'b1;
                    if (i_col == '0) begin
                        o_n_col  = LAST_COL;
                        o_n_row  = i_row - 1'b1;
                        o_n_prow = prow_prev;
                    end else begin
                        o_n_col = i_col - 1'b1;
                    end
                    o_wr_prow = o_n_prow;
                    o_wr_col  = o_n_col;
                end
            end
            default: begin
                o_ctl.wr_en = 1'b1;
                o_wr_data   = {i_back, i_fore, i_char};
                if (i_col == LAST_COL) begin
                    o_n_col = '0;
                    if (at_bot) begin
                        o_ctl.scroll = 1'b1;
                        o_n_prow     = i_top;
                    end else begin
                        o_n_row  = i_row + 1'b1;
                        o_n_prow = prow_next;
                    end
                end else begin
                    o_n_col = i_col + 1'b1;
                end
            end
        endcase
    end

endmodule

// ===== rtl/text_console_char_writer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_char_writer
// text console: screen cell memory, cursor and scroll by row rotation
// ----------------------------------------------------------------------------
// i_cmd carries put or read beats, o_res one result beat per command.
// Screen cells sit in one ram of ROWS*COLS entries; rows form a circular
// buffer with a top-row pointer, so a scroll moves the pointer and clears
// one row instead of copying the screen.
// A put executes in S_EXEC, where its result beat is registered; a read
// addresses the ram in S_EXEC and builds its result in S_RDATA from the
// registered read data. i_cmd.ready is high only in S_IDLE, so a command
// is taken only once the last one is done; a put that scrolls then clears
// the new bottom row through the single ram port.
// Reset: cursor and top pointer go to zero, then a clearing pass zeroes all
// ROWS*COLS cells (2000 by default); i_cmd.ready stays low during it.
// Stall: one result beat is held in an output register; the next command
// is taken meanwhile and waits in execution until that beat is taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module text_console_char_writer #(
    parameter int COLS = tccw_pkg::DEF_COLS,
    parameter int ROWS = tccw_pkg::DEF_ROWS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    tccw_in_if.sink      i_cmd,
    tccw_out_if.source   o_res
);

    localparam int CW    = $clog2(COLS);
    localparam int RW    = $clog2(ROWS);
    localparam int DEPTH = ROWS * COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int OCW   = tccw_pkg::PORT_COL_W;
    localparam int ORW   = tccw_pkg::PORT_ROW_W;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_EXEC  = 4'b0100,
        S_RDATA = 4'b1000
    } t_state;

    // control registers
    t_state        r_state, n_state;
    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    logic [RW-1:0] r_prow, n_prow;
    logic [RW-1:0] r_top, n_top;
    logic [AW-1:0] r_clr_addr, n_clr_addr;
    logic [AW-1:0] r_clr_last, n_clr_last;
    logic          r_out_valid, n_out_valid;
    logic          r_rd_ok, n_rd_ok;

    // command and result payload registers
    logic                                r_op;
    logic [tccw_pkg::CHAR_W-1:0]         r_char;
    logic [tccw_pkg::COLOR_W-1:0]        r_back;
    logic [tccw_pkg::COLOR_W-1:0]        r_fore;
    logic [tccw_pkg::PORT_ROW_W-1:0]     r_rrow;
    logic [tccw_pkg::PORT_COL_W-1:0]     r_rcol;
    logic [tccw_pkg::CELL_W-1:0]         r_cell, n_cell;
    logic [OCW-1:0]                      r_ocol, n_ocol;
    logic [ORW-1:0]                      r_orow, n_orow;
    logic                                r_oscroll, n_oscroll;

    // put plan
    tccw_pkg::t_put_ctl          put_ctl;
    logic [RW-1:0]               put_prow;
    logic [CW-1:0]               put_col;
    logic [tccw_pkg::CELL_W-1:0] put_data;
    logic [CW-1:0]               put_n_col;
    logic [RW-1:0]               put_n_row;
    logic [RW-1:0]               put_n_prow;

    // ram port
    logic                        mem_we;
    logic [AW-1:0]               mem_addr;
    logic [tccw_pkg::CELL_W-1:0] mem_wdata;
    logic [tccw_pkg::CELL_W-1:0] mem_rdata;

    // read address mapping
    logic          rd_ok;
    logic [RW:0]   rd_sum;
    logic [RW-1:0] rd_prow;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] clr_base;
    logic          out_free;
    logic          cmd_beat;

    tccw_cursor #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) u_cursor (
        .i_col     (r_col),
        .i_row     (r_row),
        .i_prow    (r_prow),
        .i_top     (r_top),
        .i_char    (r_char),
        .i_back    (r_back),
        .i_fore    (r_fore),
        .o_ctl     (put_ctl),
        .o_wr_prow (put_prow),
        .o_wr_col  (put_col),
        .o_wr_data (put_data),
        .o_n_col   (put_n_col),
        .o_n_row   (put_n_row),
        .o_n_prow  (put_n_prow)
    );

    tccw_ram #(
        .WIDTH (tccw_pkg::CELL_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    // handshake
    assign i_cmd.ready = (r_state == S_IDLE);
    assign cmd_beat    = i_cmd.valid && i_cmd.ready;
    assign out_free    = !r_out_valid || o_res.ready;

    // logical read row to physical row, out of range reads answer zero
    assign rd_ok   = (int'(r_rrow) < ROWS) && (int'(r_rcol) < COLS);
    assign rd_sum  = (RW + 1)'(RW'(r_rrow)) + (RW + 1)'(r_top);
    assign rd_prow = (rd_sum >= (RW + 1)'(ROWS)) ? RW'(rd_sum - (RW + 1)'(ROWS))
                                                 : RW'(rd_sum);
    assign rd_addr = AW'(rd_prow * COLS) + AW'(CW'(r_rcol));

    // cell address of a put and base of the row freed by a scroll
    assign wr_addr  = AW'(put_prow * COLS) + AW'(put_col);
    assign clr_base = AW'(r_top * COLS);

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_col       = r_col;
        n_row       = r_row;
        n_prow      = r_prow;
        n_top       = r_top;
        n_clr_addr  = r_clr_addr;
        n_clr_last  = r_clr_last;
        n_rd_ok     = r_rd_ok;
        n_out_valid = r_out_valid && !o_res.ready;
        n_cell      = r_cell;
        n_ocol      = r_ocol;
        n_orow      = r_orow;
        n_oscroll   = r_oscroll;
        mem_we      = 1'b0;
        mem_addr    = rd_addr;
        mem_wdata   = '0;
        case (r_state)
            S_CLEAR: begin
                mem_we   = 1'b1;
                mem_addr = r_clr_addr;
                if (r_clr_addr == r_clr_last) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + 1'b1;
                end
            end
            S_IDLE: begin
                if (cmd_beat) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    if (r_op == tccw_pkg::OP_READ) begin
                        n_rd_ok = rd_ok;
                        n_state = S_RDATA;
                    end else begin
                        mem_we      = put_ctl.wr_en;
                        mem_addr    = wr_addr;
                        mem_wdata   = put_data;
                        n_col       = put_n_col;
                        n_row       = put_n_row;
                        n_prow      = put_n_prow;
                        n_out_valid = 1'b1;
                        n_cell      = '0;
                        n_ocol      = OCW'(put_n_col);
                        n_orow      = ORW'(put_n_row);
                        n_oscroll   = put_ctl.scroll;
                        if (put_ctl.scroll) begin
                            n_top      = (r_top == RW'(ROWS - 1)) ? '0 : r_top + 1'b1;
                            n_clr_addr = clr_base;
                            n_clr_last = clr_base + AW'(COLS - 1);
                            n_state    = S_CLEAR;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            S_RDATA: begin
                n_out_valid = 1'b1;
                n_cell      = r_rd_ok ? mem_rdata : '0;
                n_ocol      = OCW'(r_col);
                n_orow      = ORW'(r_row);
                n_oscroll   = 1'b0;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_col       <= '0;
            r_row       <= '0;
            r_prow      <= '0;
            r_top       <= '0;
            r_clr_addr  <= '0;
            r_clr_last  <= AW'(DEPTH - 1);
            r_out_valid <= 1'b0;
            r_rd_ok     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_col       <= n_col;
            r_row       <= n_row;
            r_prow      <= n_prow;
            r_top       <= n_top;
            r_clr_addr  <= n_clr_addr;
            r_clr_last  <= n_clr_last;
            r_out_valid <= n_out_valid;
            r_rd_ok     <= n_rd_ok;
        end
    end

    // payload capture
    always_ff @(posedge i_clk) begin
        if (cmd_beat) begin
            r_op   <= i_cmd.opcode;
            r_char <= i_cmd.char_code;
            r_back <= i_cmd.back_color;
            r_fore <= i_cmd.fore_color;
            r_rrow <= i_cmd.read_row;
            r_rcol <= i_cmd.read_col;
        end
        r_cell    <= n_cell;
        r_ocol    <= n_ocol;
        r_orow    <= n_orow;
        r_oscroll <= n_oscroll;
    end

    // result beat
    assign o_res.valid      = r_out_valid;
    assign o_res.cell_value = r_cell;
    assign o_res.cursor_col = r_ocol;
    assign o_res.cursor_row = r_orow;
    assign o_res.did_scroll = r_oscroll;

    // checks
    `ASSERT_ALWAYS(a_cursor_range, i_clk, i_rst_n, (int'(r_col) < COLS) && (int'(r_row) < ROWS), "cursor out of screen")
    `ASSERT_ALWAYS(a_prow_map, i_clk, i_rst_n, (int'(r_prow) == int'(r_row) + int'(r_top)) || (int'(r_prow) + ROWS == int'(r_row) + int'(r_top)), "physical cursor row out of step with top pointer")
    `ASSERT_IMPLY(a_scroll_pos, i_clk, i_rst_n, r_out_valid && r_oscroll, (r_ocol == '0) && (r_orow == ORW'(ROWS - 1)), "scroll beat not at bottom row start")
    `ASSERT_IMPLY(a_clear_bound, i_clk, i_rst_n, r_state == S_CLEAR, r_clr_addr <= r_clr_last, "clear sweep past its end")

endmodule
